### src/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

    // Element width of every matrix entry on the ports
    localparam int ELEM_W = 32;
    // Entries of one 3x3 matrix
    localparam int NUM_ENT = 9;

    typedef logic signed [ELEM_W-1:0] elem_t;

    // One request: column-major matrix entries
    typedef struct packed {
        elem_t a_c0_r0;
        elem_t a_c0_r1;
        elem_t a_c0_r2;
        elem_t a_c1_r0;
        elem_t a_c1_r1;
        elem_t a_c1_r2;
        elem_t a_c2_r0;
        elem_t a_c2_r1;
        elem_t a_c2_r2;
    } in_t;

    // One result: column-major inverse entries and flags
    typedef struct packed {
        elem_t inv_c0_r0;
        elem_t inv_c0_r1;
        elem_t inv_c0_r2;
        elem_t inv_c1_r0;
        elem_t inv_c1_r1;
        elem_t inv_c1_r2;
        elem_t inv_c2_r0;
        elem_t inv_c2_r1;
        elem_t inv_c2_r2;
        logic  singular;
        logic  saturated;
    } out_t;

    // Control that travels along the divider stages
    typedef struct packed {
        logic valid;
        logic singular;
    } ctl_t;

endpackage
`default_nettype wire

### src/m3i_div_step.sv
`default_nettype none
// One restoring-division step for all nine lanes: decides quotient bit SHIFT.
module m3i_div_step #(
    parameter int RW    = 132,
    parameter int QW    = 32,
    parameter int SHIFT = 0
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire m3i_pkg::ctl_t                          ctl,
    input  wire logic [m3i_pkg::NUM_ENT-1:0][RW-1:0]    rem,
    input  wire logic [m3i_pkg::NUM_ENT-1:0][QW-1:0]    quo,
    input  wire logic [RW-1:0]                          den,
    input  wire logic [m3i_pkg::NUM_ENT-1:0]            neg,
    input  wire logic [m3i_pkg::NUM_ENT-1:0]            big,
    output m3i_pkg::ctl_t                               ctl_o,
    output logic [m3i_pkg::NUM_ENT-1:0][RW-1:0]         rem_o,
    output logic [m3i_pkg::NUM_ENT-1:0][QW-1:0]         quo_o,
    output logic [RW-1:0]                               den_o,
    output logic [m3i_pkg::NUM_ENT-1:0]                 neg_o,
    output logic [m3i_pkg::NUM_ENT-1:0]                 big_o
);

    m3i_pkg::ctl_t                              ctl_reg;
    logic [m3i_pkg::NUM_ENT-1:0][RW-1:0]        rem_reg, rem_next;
    logic [m3i_pkg::NUM_ENT-1:0][QW-1:0]        quo_reg, quo_next;
    logic [RW-1:0]                              den_reg;
    logic [m3i_pkg::NUM_ENT-1:0]                neg_reg, big_reg;
    logic [RW-1:0]                              dsh;

    // Divisor aligned to this quotient bit
    assign dsh = den << SHIFT;

    // Compare and subtract per lane
    always_comb
    begin
        for (int l = 0; l < m3i_pkg::NUM_ENT; l++)
        begin
            rem_next[l] = rem[l];
            quo_next[l] = quo[l];
            if (rem[l] >= dsh)
            begin
                rem_next[l] = rem[l] - dsh;
                quo_next[l][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den;
            neg_reg <= neg;
            big_reg <= big;
        end
    end

    assign ctl_o = ctl_reg;
    assign rem_o = rem_reg;
    assign quo_o = quo_reg;
    assign den_o = den_reg;
    assign neg_o = neg_reg;
    assign big_o = big_reg;

endmodule
`default_nettype wire

### src/matrix3_inverse.sv
// matrix3_inverse: signed 3x3 fixed-point inverse; one per cycle if unstalled.
// Request channel (req_valid, req_stall, req): nine column-major entries,
// 32-bit signed with FRAC_BITS fraction bits. A request is taken at a clock
// edge with req_valid high and req_stall low.
// Result channel (rsp_valid, rsp_stall, rsp): nine inverse entries in the
// same format, truncated toward zero and saturated, plus singular (zero
// determinant, all entries zero) and saturated (an entry was clipped).
// Pipeline: 8 cofactor/determinant stages, one restoring-division stage per
// quotient bit for 32 bits, one output register. Throughput: one matrix per
// cycle unless the result is stalled; the nine lanes share each division
// stage and the whole pipe advances together.
// When the result is stalled the whole pipeline holds, req_stall rises in
// the same cycle and nothing is lost or repeated.
// Reset clears every valid bit; no results appear until new requests enter.
`default_nettype none
module matrix3_inverse #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire m3i_pkg::in_t   req,
    output logic                rsp_valid,
    input  wire logic           rsp_stall,
    output m3i_pkg::out_t       rsp
);

    localparam int E  = m3i_pkg::ELEM_W;
    localparam int N  = m3i_pkg::NUM_ENT;
    localparam int PW = 2 * E;
    localparam int CW = 2 * E + 1;
    localparam int MW = 2 * E + 1;
    localparam int DW = 3 * E + 3;
    localparam int NW = CW + 2 * FRAC_BITS + 1;
    localparam int RW = ((NW > DW + E) ? NW : DW + E) + 1;

    // Operand indexes of each cofactor: a*b - c*d
    localparam int CA [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
    localparam int CB [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
    localparam int CC [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
    localparam int CD [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
    // Entries used in the determinant expansion
    localparam int DV [3] = '{0, 3, 6};

    localparam logic [E-1:0] MAXV = {1'b0, {(E-1){1'b1}}};
    localparam logic [E-1:0] MINV = {1'b1, {(E-1){1'b0}}};

    logic adv;
    logic rsp_valid_reg;
    m3i_pkg::out_t rsp_reg, rsp_next;
    logic [7:0] vld_reg;

    // Pipe advances unless a finished result is held
    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[6:0], req_valid};
        end
    end

    // Stage 1: capture request
    m3i_pkg::in_t x_reg;
    logic signed [E-1:0] v [N];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= req;
        end
    end

    assign v[0] = x_reg.a_c0_r0;
    assign v[1] = x_reg.a_c0_r1;
    assign v[2] = x_reg.a_c0_r2;
    assign v[3] = x_reg.a_c1_r0;
    assign v[4] = x_reg.a_c1_r1;
    assign v[5] = x_reg.a_c1_r2;
    assign v[6] = x_reg.a_c2_r0;
    assign v[7] = x_reg.a_c2_r1;
    assign v[8] = x_reg.a_c2_r2;

    // Stage 2: cofactor products
    logic signed [PW-1:0] pa_reg [N];
    logic signed [PW-1:0] pb_reg [N];
    logic signed [E-1:0]  w2_reg [3];
    // Stage 3: cofactors
    logic signed [CW-1:0] cof3_reg [N];
    logic signed [E-1:0]  w3_reg [3];
    // Stage 4: determinant partial products
    logic signed [MW-1:0] pl_reg [3];
    logic signed [MW-1:0] ph_reg [3];
    logic signed [CW-1:0] cof4_reg [N];
    // Stage 5: determinant terms
    logic signed [DW-1:0] term_reg [3];
    logic signed [CW-1:0] cof5_reg [N];
    // Stage 6: determinant
    logic signed [DW-1:0] det_reg;
    logic signed [CW-1:0] cof6_reg [N];
    // Stage 7: magnitudes and signs
    logic signed [NW-1:0] num [N];
    logic [NW-1:0]        num_mag [N];
    logic [DW-1:0]        det_mag;
    logic [RW-1:0]        an_reg [N];
    logic [RW-1:0]        ad_reg;
    logic [N-1:0]         neg_reg;
    logic                 sing_reg;
    // Stage 8: quotient overflow check
    logic [N-1:0][RW-1:0] rem8_reg;
    logic [RW-1:0]        ad8_reg;
    logic [N-1:0]         neg8_reg;
    logic [N-1:0]         big8_reg;
    logic                 sing8_reg;
    logic [RW-1:0]        ad_top;

    assign ad_top = ad_reg << E;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_lane
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    pa_reg[g]   <= v[CA[g]] * v[CB[g]];
                    pb_reg[g]   <= v[CC[g]] * v[CD[g]];
                    cof3_reg[g] <= CW'(pa_reg[g]) - CW'(pb_reg[g]);
                    cof4_reg[g] <= cof3_reg[g];
                    cof5_reg[g] <= cof4_reg[g];
                    cof6_reg[g] <= cof5_reg[g];
                    an_reg[g]   <= RW'(num_mag[g]);
                    rem8_reg[g] <= an_reg[g];
                    big8_reg[g] <= (an_reg[g] >= ad_top);
                    neg_reg[g]  <= num[g][NW-1] ^ det_reg[DW-1];
                end
            end

            // Scaled numerator, sign flipped on checkerboard places
            always_comb
            begin
                num[g] = NW'(cof6_reg[g]) <<< (2 * FRAC_BITS);
                if ((g % 2) == 1)
                begin
                    num[g] = -num[g];
                end
                num_mag[g] = num[g][NW-1] ? NW'(-num[g]) : NW'(num[g]);
            end
        end

        for (g = 0; g < 3; g++)
        begin : g_det
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    w2_reg[g]   <= v[DV[g]];
                    w3_reg[g]   <= w2_reg[g];
                    pl_reg[g]   <= w3_reg[g] * $signed({1'b0, cof3_reg[g][E-1:0]});
                    ph_reg[g]   <= w3_reg[g] * $signed(cof3_reg[g][CW-1:E]);
                    term_reg[g] <= (DW'(ph_reg[g]) <<< E) + DW'(pl_reg[g]);
                end
            end
        end
    endgenerate

    assign det_mag = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det_reg   <= term_reg[0] - term_reg[1] + term_reg[2];
            ad_reg    <= RW'(det_mag);
            sing_reg  <= (det_reg == '0);
            ad8_reg   <= ad_reg;
            neg8_reg  <= neg_reg;
            sing8_reg <= sing_reg;
        end
    end

    // Restoring division, one quotient bit per stage, MSB first
    m3i_pkg::ctl_t        d_ctl [E+1];
    logic [N-1:0][RW-1:0] d_rem [E+1];
    logic [N-1:0][E-1:0]  d_quo [E+1];
    logic [RW-1:0]        d_den [E+1];
    logic [N-1:0]         d_neg [E+1];
    logic [N-1:0]         d_big [E+1];

    assign d_ctl[0] = '{valid: vld_reg[7], singular: sing8_reg};
    assign d_rem[0] = rem8_reg;
    assign d_quo[0] = '0;
    assign d_den[0] = ad8_reg;
    assign d_neg[0] = neg8_reg;
    assign d_big[0] = big8_reg;

    generate
        for (g = 0; g < E; g++)
        begin : g_div
            m3i_div_step #(
                .RW    (RW),
                .QW    (E),
                .SHIFT (E - 1 - g)
            ) u_step (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (adv),
                .ctl   (d_ctl[g]),
                .rem   (d_rem[g]),
                .quo   (d_quo[g]),
                .den   (d_den[g]),
                .neg   (d_neg[g]),
                .big   (d_big[g]),
                .ctl_o (d_ctl[g+1]),
                .rem_o (d_rem[g+1]),
                .quo_o (d_quo[g+1]),
                .den_o (d_den[g+1]),
                .neg_o (d_neg[g+1]),
                .big_o (d_big[g+1])
            );
        end
    endgenerate

    // Sign, saturation and singular override
    logic [E-1:0] res [N];
    logic [N-1:0] ovf;
    logic [E-1:0] mag;

    always_comb
    begin
        for (int l = 0; l < N; l++)
        begin
            mag = d_quo[E][l];
            ovf[l] = d_big[E][l] |
                (d_neg[E][l] ? (mag[E-1] & (|mag[E-2:0])) : mag[E-1]);
            if (d_ctl[E].singular)
            begin
                res[l] = '0;
            end
            else if (ovf[l])
            begin
                res[l] = d_neg[E][l] ? MINV : MAXV;
            end
            else
            begin
                res[l] = d_neg[E][l] ? E'(-mag) : mag;
            end
        end
        rsp_next.inv_c0_r0 = res[0];
        rsp_next.inv_c0_r1 = res[1];
        rsp_next.inv_c0_r2 = res[2];
        rsp_next.inv_c1_r0 = res[3];
        rsp_next.inv_c1_r1 = res[4];
        rsp_next.inv_c1_r2 = res[5];
        rsp_next.inv_c2_r0 = res[6];
        rsp_next.inv_c2_r1 = res[7];
        rsp_next.inv_c2_r2 = res[8];
        rsp_next.singular  = d_ctl[E].singular;
        rsp_next.saturated = !d_ctl[E].singular && (|ovf);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= d_ctl[E].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A singular result carries zeros and no saturation
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.singular) |->
            (!rsp.saturated && rsp.inv_c0_r0 == '0 && rsp.inv_c2_r2 == '0))
        else $error("singular result not cleared");

    // A new result only appears after the pipe advanced
    a_rise_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_stall))
        else $error("result valid rose while pipe held");

endmodule
`default_nettype wire
